[rtl/tidpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tidpc_pkg;

   // Page geometry
   localparam int PAGE_BYTES = 128;
   localparam int ADDR_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int CODE_W     = 5;
   localparam int HELD_W     = 16;   // widest held text field
   localparam int HELD_POS_W = 4;

   // Entries in the queue between classifier and emitter
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Finding codes, in rule order
   localparam logic [CODE_W-1:0] F_NONE             = 5'd0;
   localparam logic [CODE_W-1:0] F_ID_RESERVED      = 5'd1;
   localparam logic [CODE_W-1:0] F_ID_VENDOR        = 5'd2;
   localparam logic [CODE_W-1:0] F_EXT_ID           = 5'd3;
   localparam logic [CODE_W-1:0] F_CONN_RESERVED    = 5'd4;
   localparam logic [CODE_W-1:0] F_CONN_VENDOR      = 5'd5;
   localparam logic [CODE_W-1:0] F_BYTE5_RESERVED   = 5'd6;
   localparam logic [CODE_W-1:0] F_BYTE8_RESERVED   = 5'd7;
   localparam logic [CODE_W-1:0] F_BYTE9_RESERVED   = 5'd8;
   localparam logic [CODE_W-1:0] F_ENCODING         = 5'd9;
   localparam logic [CODE_W-1:0] F_RATE_ZERO        = 5'd10;
   localparam logic [CODE_W-1:0] F_MAX_RATE_ZERO    = 5'd11;
   localparam logic [CODE_W-1:0] F_MAX_RATE_LOW     = 5'd12;
   localparam logic [CODE_W-1:0] F_MIN_RATE_HIGH    = 5'd13;
   localparam logic [CODE_W-1:0] F_RATE_ID_ODD      = 5'd14;
   localparam logic [CODE_W-1:0] F_RATE_ID_RESERVED = 5'd15;
   localparam logic [CODE_W-1:0] F_UNPRINTABLE      = 5'd16;
   localparam logic [CODE_W-1:0] F_BYTE36_RESERVED  = 5'd17;
   localparam logic [CODE_W-1:0] F_CABLE_CLASH      = 5'd18;
   localparam logic [CODE_W-1:0] F_PASSIVE_BYTE60   = 5'd19;
   localparam logic [CODE_W-1:0] F_PASSIVE_BYTE61   = 5'd20;
   localparam logic [CODE_W-1:0] F_ACTIVE_BYTE60    = 5'd21;
   localparam logic [CODE_W-1:0] F_ACTIVE_BYTE61    = 5'd22;
   localparam logic [CODE_W-1:0] F_BYTE62_RESERVED  = 5'd23;
   localparam logic [CODE_W-1:0] F_CC_BASE          = 5'd24;
   localparam logic [CODE_W-1:0] F_BYTE64_RESERVED  = 5'd25;
   localparam logic [CODE_W-1:0] F_BYTE65_CLASH     = 5'd26;
   localparam logic [CODE_W-1:0] F_BYTE65_RESERVED  = 5'd27;
   localparam logic [CODE_W-1:0] F_YEAR             = 5'd28;
   localparam logic [CODE_W-1:0] F_MONTH            = 5'd29;
   localparam logic [CODE_W-1:0] F_DAY              = 5'd30;
   localparam logic [CODE_W-1:0] F_CC_EXT           = 5'd31;

   // Classified work for one page byte: up to two immediate findings,
   // plus a mask of unprintable positions of a held field that just closed.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        imm_cnt;
      logic [CODE_W-1:0] code0;
      logic              warn0;
      logic [CODE_W-1:0] code1;
      logic              warn1;
      logic [HELD_W-1:0] mask;
      logic [ADDR_W-1:0] mask_base;
   } job_type;

endpackage

`default_nettype wire

[rtl/tidpc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tidpc_front
   import tidpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [ADDR_W-1:0] byte_address,
   input  wire logic [BYTE_W-1:0] byte_value,
   output job_type                job
);

   // Page byte addresses with rules of their own
   localparam logic [ADDR_W-1:0] A_ID         = 7'd0;
   localparam logic [ADDR_W-1:0] A_EXT_ID     = 7'd1;
   localparam logic [ADDR_W-1:0] A_CONNECTOR  = 7'd2;
   localparam logic [ADDR_W-1:0] A_BYTE5      = 7'd5;
   localparam logic [ADDR_W-1:0] A_CABLE      = 7'd8;
   localparam logic [ADDR_W-1:0] A_BYTE9      = 7'd9;
   localparam logic [ADDR_W-1:0] A_ENCODING   = 7'd11;
   localparam logic [ADDR_W-1:0] A_NOM_RATE   = 7'd12;
   localparam logic [ADDR_W-1:0] A_RATE_ID    = 7'd13;
   localparam logic [ADDR_W-1:0] A_BYTE36     = 7'd36;
   localparam logic [ADDR_W-1:0] A_BYTE60     = 7'd60;
   localparam logic [ADDR_W-1:0] A_BYTE61     = 7'd61;
   localparam logic [ADDR_W-1:0] A_BYTE62     = 7'd62;
   localparam logic [ADDR_W-1:0] A_CC_BASE    = 7'd63;
   localparam logic [ADDR_W-1:0] A_BYTE64     = 7'd64;
   localparam logic [ADDR_W-1:0] A_BYTE65     = 7'd65;
   localparam logic [ADDR_W-1:0] A_MAX_RATE   = 7'd66;
   localparam logic [ADDR_W-1:0] A_MIN_RATE   = 7'd67;
   localparam logic [ADDR_W-1:0] A_YEAR_HI    = 7'd84;
   localparam logic [ADDR_W-1:0] A_YEAR_LO    = 7'd85;
   localparam logic [ADDR_W-1:0] A_MONTH_HI   = 7'd86;
   localparam logic [ADDR_W-1:0] A_MONTH_LO   = 7'd87;
   localparam logic [ADDR_W-1:0] A_DAY_HI     = 7'd88;
   localparam logic [ADDR_W-1:0] A_DAY_LO     = 7'd89;
   localparam logic [ADDR_W-1:0] A_CC_EXT     = 7'd95;
   localparam logic [ADDR_W-1:0] A_BASE_LAST  = 7'd62;
   localparam logic [ADDR_W-1:0] A_EXT_LAST   = 7'd94;

   // Held text fields: part number, revision, serial number
   localparam logic [ADDR_W-1:0] PART_START   = 7'd40;
   localparam logic [ADDR_W-1:0] PART_END     = 7'd55;
   localparam logic [ADDR_W-1:0] REV_START    = 7'd56;
   localparam logic [ADDR_W-1:0] REV_END      = 7'd59;
   localparam logic [ADDR_W-1:0] SERIAL_START = 7'd68;
   localparam logic [ADDR_W-1:0] SERIAL_END   = 7'd83;

   localparam logic [1:0] CABLE_PASSIVE = 2'b01;
   localparam logic [1:0] CABLE_ACTIVE  = 2'b10;
   localparam logic [1:0] CABLE_BOTH    = 2'b11;

   // byte 66 * 250 < 25400 reduces to byte 66 below this bound
   localparam int NOMINAL_MIN = 25400;
   localparam int RATE_UNIT   = 250;
   localparam logic [BYTE_W-1:0] RATE_FLOOR =
      BYTE_W'((NOMINAL_MIN + RATE_UNIT - 1) / RATE_UNIT);
   localparam logic [ADDR_W:0] PAGE_LIMIT = (ADDR_W + 1)'(PAGE_BYTES);

   logic [1:0]        cable_mode_ff, cable_mode_in;
   logic              rate_sat_ff, rate_sat_in;
   logic [7:0]        base_sum_ff, base_sum_in;
   logic [7:0]        ext_sum_ff, ext_sum_in;
   logic [HELD_W-1:0] pending_ff, pending_in;
   logic              nonzero_ff, nonzero_in;
   logic              digit_ok_ff, digit_ok_in;
   logic [3:0]        tens_ff, tens_in;

   logic                  in_page;
   logic                  is_printable;
   logic                  is_digit;
   logic [6:0]            pair_val;
   logic                  in_held;
   logic [ADDR_W-1:0]     held_start;
   logic [HELD_POS_W-1:0] held_last;
   logic [ADDR_W-1:0]     held_offset;
   logic [HELD_POS_W-1:0] held_pos;
   logic [HELD_W-1:0]     pend_next;
   logic                  nz_next;

   // Append one immediate finding
   function automatic job_type push(input job_type j, input logic [CODE_W-1:0] code,
                                    input logic warn);
      job_type r;
      r = j;
      if (j.imm_cnt == 2'd0) begin
         r.code0 = code;
         r.warn0 = warn;
      end else begin
         r.code1 = code;
         r.warn1 = warn;
      end
      r.imm_cnt = j.imm_cnt + 2'd1;
      return r;
   endfunction

   assign in_page      = {1'b0, byte_address} < PAGE_LIMIT;
   assign is_printable = (byte_value >= 8'h20) && (byte_value <= 8'h7E);
   assign is_digit     = (byte_value >= 8'h30) && (byte_value <= 8'h39);
   assign pair_val     = 7'({tens_ff, 3'b000}) + 7'({tens_ff, 1'b0}) + 7'(byte_value[3:0]);

   // Which held field this byte belongs to
   always_comb begin
      in_held    = 1'b1;
      held_start = PART_START;
      held_last  = HELD_POS_W'(PART_END - PART_START);
      if ((byte_address >= PART_START) && (byte_address <= PART_END)) begin
         held_start = PART_START;
         held_last  = HELD_POS_W'(PART_END - PART_START);
      end else if ((byte_address >= REV_START) && (byte_address <= REV_END)) begin
         held_start = REV_START;
         held_last  = HELD_POS_W'(REV_END - REV_START);
      end else if ((byte_address >= SERIAL_START) && (byte_address <= SERIAL_END)) begin
         held_start = SERIAL_START;
         held_last  = HELD_POS_W'(SERIAL_END - SERIAL_START);
      end else begin
         in_held = 1'b0;
      end
      held_offset = byte_address - held_start;
      held_pos    = held_offset[HELD_POS_W-1:0];
      pend_next   = ((held_pos == '0) ? '0 : pending_ff)
                    | (HELD_W'(!is_printable) << held_pos);
      nz_next     = ((held_pos == '0) ? 1'b0 : nonzero_ff) | (byte_value != 8'h00);
   end

   // Classification and state update
   always_comb begin
      job           = '0;
      job.addr      = byte_address;
      job.mask_base = held_start;
      cable_mode_in = cable_mode_ff;
      rate_sat_in   = rate_sat_ff;
      base_sum_in   = base_sum_ff;
      ext_sum_in    = ext_sum_ff;
      pending_in    = pending_ff;
      nonzero_in    = nonzero_ff;
      digit_ok_in   = digit_ok_ff;
      tens_in       = tens_ff;

      if (in_page) begin
         // running checksums, restarting at the first byte of each range
         if (byte_address <= A_BASE_LAST) begin
            base_sum_in = ((byte_address == A_ID) ? 8'h00 : base_sum_ff) + byte_value;
         end
         if ((byte_address >= A_BYTE64) && (byte_address <= A_EXT_LAST)) begin
            ext_sum_in = ((byte_address == A_BYTE64) ? 8'h00 : ext_sum_ff) + byte_value;
         end

         case (byte_address)
            A_ID: begin
               if ((byte_value >= 8'h04) && (byte_value <= 8'h7F)) begin
                  job = push(job, F_ID_RESERVED, 1'b0);
               end
               if (byte_value >= 8'h80) begin
                  job = push(job, F_ID_VENDOR, 1'b1);
               end
            end
            A_EXT_ID: begin
               if (byte_value >= 8'h08) begin
                  job = push(job, F_EXT_ID, 1'b0);
               end
            end
            A_CONNECTOR: begin
               if (((byte_value >= 8'h0E) && (byte_value <= 8'h1F)) ||
                   ((byte_value >= 8'h29) && (byte_value <= 8'h7F))) begin
                  job = push(job, F_CONN_RESERVED, 1'b0);
               end
               if (byte_value >= 8'h80) begin
                  job = push(job, F_CONN_VENDOR, 1'b1);
               end
            end
            A_BYTE5: begin
               if ((byte_value & 8'h88) != 8'h00) begin
                  job = push(job, F_BYTE5_RESERVED, 1'b0);
               end
            end
            A_CABLE: begin
               cable_mode_in = {byte_value[3], byte_value[2]};
               if (byte_value[1:0] != 2'b00) begin
                  job = push(job, F_BYTE8_RESERVED, 1'b0);
               end
               if ({byte_value[3], byte_value[2]} == CABLE_BOTH) begin
                  job = push(job, F_CABLE_CLASH, 1'b0);
               end
            end
            A_BYTE9: begin
               if (byte_value[1]) begin
                  job = push(job, F_BYTE9_RESERVED, 1'b0);
               end
            end
            A_ENCODING: begin
               if (byte_value >= 8'h09) begin
                  job = push(job, F_ENCODING, 1'b0);
               end
            end
            A_NOM_RATE: begin
               rate_sat_in = (byte_value == 8'hFF);
               if (byte_value == 8'h00) begin
                  job = push(job, F_RATE_ZERO, 1'b1);
               end
            end
            A_RATE_ID: begin
               if ((byte_value >= 8'h03) && (byte_value <= 8'h11) && byte_value[0]) begin
                  job = push(job, F_RATE_ID_ODD, 1'b1);
               end
               if (((byte_value >= 8'h12) && (byte_value <= 8'h1F)) ||
                   (byte_value >= 8'h21)) begin
                  job = push(job, F_RATE_ID_RESERVED, 1'b0);
               end
            end
            A_BYTE36: begin
               if ((byte_value == 8'h0A) || (byte_value == 8'h0F) ||
                   ((byte_value >= 8'h3B) && (byte_value <= 8'h3E)) ||
                   ((byte_value >= 8'h4D) && (byte_value <= 8'h7E)) ||
                   (byte_value >= 8'h82)) begin
                  job = push(job, F_BYTE36_RESERVED, 1'b0);
               end
            end
            A_BYTE60: begin
               if ((cable_mode_ff == CABLE_PASSIVE) && ((byte_value & 8'hFC) != 8'h00)) begin
                  job = push(job, F_PASSIVE_BYTE60, 1'b0);
               end
               if ((cable_mode_ff == CABLE_ACTIVE) && ((byte_value & 8'hF0) != 8'h00)) begin
                  job = push(job, F_ACTIVE_BYTE60, 1'b0);
               end
            end
            A_BYTE61: begin
               if ((cable_mode_ff == CABLE_PASSIVE) && (byte_value != 8'h00)) begin
                  job = push(job, F_PASSIVE_BYTE61, 1'b0);
               end
               if ((cable_mode_ff == CABLE_ACTIVE) && (byte_value != 8'h00)) begin
                  job = push(job, F_ACTIVE_BYTE61, 1'b0);
               end
            end
            A_BYTE62: begin
               if ((byte_value & 8'hFE) != 8'h00) begin
                  job = push(job, F_BYTE62_RESERVED, 1'b0);
               end
            end
            A_CC_BASE: begin
               if (byte_value != base_sum_ff) begin
                  job = push(job, F_CC_BASE, 1'b0);
               end
            end
            A_BYTE64: begin
               if (byte_value[7]) begin
                  job = push(job, F_BYTE64_RESERVED, 1'b0);
               end
            end
            A_BYTE65: begin
               if (byte_value[2:1] == 2'b11) begin
                  job = push(job, F_BYTE65_CLASH, 1'b0);
               end
               if (byte_value[0]) begin
                  job = push(job, F_BYTE65_RESERVED, 1'b0);
               end
            end
            A_MAX_RATE: begin
               if (rate_sat_ff) begin
                  if (byte_value == 8'h00) begin
                     job = push(job, F_MAX_RATE_ZERO, 1'b1);
                  end else if (byte_value < RATE_FLOOR) begin
                     job = push(job, F_MAX_RATE_LOW, 1'b1);
                  end
               end
            end
            A_MIN_RATE: begin
               if (byte_value > 8'd100) begin
                  job = push(job, F_MIN_RATE_HIGH, 1'b1);
               end
            end
            A_YEAR_HI, A_MONTH_HI, A_DAY_HI: begin
               digit_ok_in = is_digit;
               tens_in     = is_digit ? byte_value[3:0] : 4'd0;
            end
            A_YEAR_LO: begin
               if (!digit_ok_ff || !is_digit) begin
                  job = push(job, F_YEAR, 1'b0);
               end
            end
            A_MONTH_LO: begin
               if (!digit_ok_ff || !is_digit || (pair_val == 7'd0) || (pair_val > 7'd12)) begin
                  job = push(job, F_MONTH, 1'b0);
               end
            end
            A_DAY_LO: begin
               if (!digit_ok_ff || !is_digit || (pair_val == 7'd0) || (pair_val > 7'd31)) begin
                  job = push(job, F_DAY, 1'b0);
               end
            end
            A_CC_EXT: begin
               if (byte_value != ext_sum_ff) begin
                  job = push(job, F_CC_EXT, 1'b0);
               end
            end
            default: begin
            end
         endcase

         // text fields checked byte by byte: vendor name, date code tail
         if (((byte_address >= 7'd20) && (byte_address <= 7'd35)) ||
             (byte_address == 7'd90) || (byte_address == 7'd91)) begin
            if (!is_printable) begin
               job = push(job, F_UNPRINTABLE, 1'b0);
            end
         end

         // held fields report at their last byte, only if not all zero
         if (in_held) begin
            if (held_pos == held_last) begin
               job.mask   = nz_next ? pend_next : '0;
               pending_in = '0;
               nonzero_in = 1'b0;
            end else begin
               pending_in = pend_next;
               nonzero_in = nz_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cable_mode_ff <= '0;
         rate_sat_ff   <= 1'b0;
         base_sum_ff   <= '0;
         ext_sum_ff    <= '0;
         pending_ff    <= '0;
         nonzero_ff    <= 1'b0;
         digit_ok_ff   <= 1'b0;
         tens_ff       <= '0;
      end else if (accept) begin
         cable_mode_ff <= cable_mode_in;
         rate_sat_ff   <= rate_sat_in;
         base_sum_ff   <= base_sum_in;
         ext_sum_ff    <= ext_sum_in;
         pending_ff    <= pending_in;
         nonzero_ff    <= nonzero_in;
         digit_ok_ff   <= digit_ok_in;
         tens_ff       <= tens_in;
      end
   end

endmodule

`default_nettype wire

[rtl/tidpc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tidpc_queue
   import tidpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         not_empty
);

   localparam logic [QUEUE_PTR_W-1:0] LAST_SLOT = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] FULL_CNT  = QUEUE_CNT_W'(QUEUE_DEPTH);

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/tidpc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tidpc_back
   import tidpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire job_type            head_job,
   input  wire logic               head_valid,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CODE_W-1:0]       rsp_finding,
   output logic [ADDR_W-1:0]       rsp_address,
   output logic                    rsp_warning,
   output logic                    rsp_last
);

   job_type           cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_warn_ff, rsp_warn_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              emit;
   logic              emit_last;
   job_type           cur_next;
   logic [HELD_POS_W-1:0] low_idx;

   // A job with nothing to report carries one "none" finding
   function automatic job_type normalize(input job_type j);
      job_type r;
      r = j;
      if ((j.imm_cnt == 2'd0) && (j.mask == '0)) begin
         r.imm_cnt = 2'd1;
         r.code0   = F_NONE;
         r.warn0   = 1'b0;
      end
      return r;
   endfunction

   // Lowest pending position of the held field
   always_comb begin
      low_idx = '0;
      for (int i = HELD_W - 1; i >= 0; i--) begin
         if (cur_ff.mask[i]) begin
            low_idx = HELD_POS_W'(i);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && slot_free;

   // Next result from the current job, then what is left of it
   always_comb begin
      cur_next    = cur_ff;
      rsp_code_in = rsp_code_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_warn_in = rsp_warn_ff;
      if (cur_ff.imm_cnt != 2'd0) begin
         rsp_code_in      = cur_ff.code0;
         rsp_addr_in      = cur_ff.addr;
         rsp_warn_in      = cur_ff.warn0;
         cur_next.imm_cnt = cur_ff.imm_cnt - 2'd1;
         cur_next.code0   = cur_ff.code1;
         cur_next.warn0   = cur_ff.warn1;
      end else begin
         rsp_code_in   = F_UNPRINTABLE;
         rsp_addr_in   = cur_ff.mask_base + ADDR_W'(low_idx);
         rsp_warn_in   = 1'b0;
         cur_next.mask = cur_ff.mask & (cur_ff.mask - HELD_W'(1));
      end
      emit_last   = (cur_next.imm_cnt == 2'd0) && (cur_next.mask == '0);
      rsp_last_in = emit_last;
   end

   // Job hand-off and output register
   always_comb begin
      pop          = head_valid && (!cur_valid_ff || (emit && emit_last));
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (emit) begin
         cur_in = cur_next;
         if (emit_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = normalize(head_job);
         cur_valid_in = 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_code_ff <= rsp_code_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_warn_ff <= rsp_warn_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_finding = rsp_code_ff;
   assign rsp_address = rsp_addr_ff;
   assign rsp_warning = rsp_warn_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/transceiver_id_page_checker.sv]
// An accepted byte passes the job queue, the current-job register and the output
// register. Throughput: one result per cycle when rsp_tready allows; each byte gives
// one result or more (one for most, up to sixteen at the end of a held text field).
// The two-entry job queue lets the classifier run ahead while results drain.
// Reset: synchronous, active high; clears checksums, field state, queue and rsp_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module transceiver_id_page_checker
   import tidpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // byte_address[6:0], byte_value[14:7], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // finding[4:0], finding_address[11:5], zero pad
   output logic             rsp_tuser,   // is_warning
   output logic             rsp_tlast
);

   logic              queue_full;
   logic              accept;
   job_type           new_job;
   job_type           head_job;
   logic              head_valid;
   logic              pop;
   logic [CODE_W-1:0] finding;
   logic [ADDR_W-1:0] finding_address;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Classifier: keeps page state and turns each byte into a job
   tidpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_address (req_tdata[ADDR_W-1:0]),
      .byte_value   (req_tdata[ADDR_W+BYTE_W-1:ADDR_W]),
      .job          (new_job)
   );

   tidpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_job  (new_job),
      .full      (queue_full),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (head_valid)
   );

   // Emitter: one result transaction per cycle while rsp_tready allows
   tidpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_finding (finding),
      .rsp_address (finding_address),
      .rsp_warning (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, finding_address, finding};

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import tidpc_pkg::*;

   // Idling phases of the run
   typedef enum logic [1:0] {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   // One page byte waiting to be sent
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] value;
      idle_phase_type    phase;
      logic              drain;   // hold off until every predicted finding has arrived
   } page_byte_type;

   // One predicted finding
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [ADDR_W-1:0] addr;
      logic              warn;
      logic              last;
   } page_finding_type;

   localparam int PLAN_TOTAL   = 500;      // directed bytes plus random ones
   localparam int MAX_FINDINGS = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 20;

   // Held text fields: vendor part number, revision, serial number
   localparam int PART_START   = 40;
   localparam int PART_LEN     = 16;
   localparam int REV_START    = 56;
   localparam int REV_LEN      = 4;
   localparam int SERIAL_START = 68;
   localparam int SERIAL_LEN   = 16;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // byte_address[6:0], byte_value[14:7], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // finding[4:0], finding_address[11:5], zero pad
   logic        rsp_tuser;         // is_warning
   logic        rsp_tlast;

   transceiver_id_page_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5ns clock = ~clock;

   // Stimulus plan and prediction bookkeeping
   page_byte_type    byte_plan[$];
   page_finding_type findings_due[$];
   page_finding_type step_findings[$];
   logic [7:0]       page_img [128];
   int               planned_n = 0;
   idle_phase_type   plan_phase = PH_FREE;
   bit               drain_next = 1'b0;
   idle_phase_type   idle_phase = PH_FREE;
   int               findings_outstanding = 0;
   int               mismatch_count = 0;
   int               result_count = 0;
   int               byte_count = 0;
   int               cycle_count = 0;
   logic [31:0]      codes_seen = '0;
   page_byte_type    next_byte;
   page_finding_type due;

   // Checker state mirrored from the block
   logic [1:0]        cable_mode = '0;      // bit 0 passive, bit 1 active
   logic              rate_saturated = 1'b0;
   logic [7:0]        base_sum = '0;
   logic [7:0]        ext_sum = '0;
   logic [HELD_W-1:0] held_bits = '0;
   logic              held_nonzero = 1'b0;
   logic              date_first_ok = 1'b0;
   logic [3:0]        date_tens = '0;

   function automatic bit is_printable(input logic [7:0] v);
      return v >= 8'h20 && v <= 8'h7E;
   endfunction

   function automatic bit is_digit(input logic [7:0] v);
      return v >= 8'h30 && v <= 8'h39;
   endfunction

   function automatic int send_idle_pct(input idle_phase_type p);
      case (p)
         PH_SEND_IDLE: return 61;
         PH_BOTH_IDLE: return 28;
         default:      return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(input idle_phase_type p);
      case (p)
         PH_RECV_STALL: return 61;
         PH_BOTH_IDLE:  return 28;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [7:0] printable_char();
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic void note(input logic [CODE_W-1:0] code, input int at, input logic warn);
      page_finding_type f;
      f.code = code;
      f.addr = ADDR_W'(at);
      f.warn = warn;
      f.last = 1'b0;
      if (step_findings.size() < MAX_FINDINGS) step_findings.insert(step_findings.size(), f);
   endfunction

   // Unprintable characters of a text field are held until its last byte
   function automatic void held_text(input int a, input logic [7:0] v, input int start,
                                     input int len);
      int pos;
      if (a >= start && a < start + len) begin
         pos = a - start;
         if (pos == 0) begin
            held_bits = '0;
            held_nonzero = 1'b0;
         end
         if (v != 0) held_nonzero = 1'b1;
         if (!is_printable(v)) held_bits[pos] = 1'b1;
         if (pos == len - 1) begin
            // an all-zero field is legal and reports nothing
            if (held_nonzero) begin
               for (int i = 0; i < len; i++)
                  if (held_bits[i]) note(F_UNPRINTABLE, start + i, 1'b0);
            end
            held_bits = '0;
            held_nonzero = 1'b0;
         end
      end
   endfunction

   // Second digit of a month or day pair
   function automatic void date_pair(input int a, input logic [7:0] v, input int maxval,
                                     input logic [CODE_W-1:0] code);
      int val;
      if (!date_first_ok || !is_digit(v)) begin
         note(code, a, 1'b0);
      end else begin
         val = date_tens * 10 + (v - 8'h30);
         if (val < 1 || val > maxval) note(code, a, 1'b0);
      end
   endfunction

   // Work out the findings of one accepted page byte
   function automatic void predict_page_byte(input logic [ADDR_W-1:0] a,
                                             input logic [BYTE_W-1:0] v);
      page_finding_type f;
      step_findings.delete();
      if (a < PAGE_BYTES) begin
         // running checksums restart at the first byte of their range
         if (a == 0) base_sum = '0;
         if (a <= 62) base_sum = base_sum + v;
         if (a == 64) ext_sum = '0;
         if (a >= 64 && a <= 94) ext_sum = ext_sum + v;

         case (a)
            0: begin
               if (v >= 8'h04 && v <= 8'h7F) note(F_ID_RESERVED, a, 1'b0);
               if (v >= 8'h80) note(F_ID_VENDOR, a, 1'b1);
            end
            1: if (v >= 8'h08) note(F_EXT_ID, a, 1'b0);
            2: begin
               if ((v >= 8'h0E && v <= 8'h1F) || (v >= 8'h29 && v <= 8'h7F))
                  note(F_CONN_RESERVED, a, 1'b0);
               if (v >= 8'h80) note(F_CONN_VENDOR, a, 1'b1);
            end
            5: if (v & 8'h88) note(F_BYTE5_RESERVED, a, 1'b0);
            8: begin
               cable_mode = {v[3], v[2]};
               if (v & 8'h03) note(F_BYTE8_RESERVED, a, 1'b0);
               if (cable_mode == 2'b11) note(F_CABLE_CLASH, a, 1'b0);
            end
            9: if (v & 8'h02) note(F_BYTE9_RESERVED, a, 1'b0);
            11: if (v >= 8'h09) note(F_ENCODING, a, 1'b0);
            12: begin
               rate_saturated = (v == 8'hFF);
               if (v == 0) note(F_RATE_ZERO, a, 1'b1);
            end
            13: begin
               if (v >= 8'h03 && v <= 8'h11 && v[0]) note(F_RATE_ID_ODD, a, 1'b1);
               if ((v >= 8'h12 && v <= 8'h1F) || v >= 8'h21)
                  note(F_RATE_ID_RESERVED, a, 1'b0);
            end
            36: begin
               if (v == 8'h0A || v == 8'h0F || (v >= 8'h3B && v <= 8'h3E) ||
                   (v >= 8'h4D && v <= 8'h7E) || v >= 8'h82)
                  note(F_BYTE36_RESERVED, a, 1'b0);
            end
            60: begin
               if (cable_mode == 2'b01 && (v & 8'hFC)) note(F_PASSIVE_BYTE60, a, 1'b0);
               if (cable_mode == 2'b10 && (v & 8'hF0)) note(F_ACTIVE_BYTE60, a, 1'b0);
            end
            61: begin
               if (cable_mode == 2'b01 && v != 0) note(F_PASSIVE_BYTE61, a, 1'b0);
               if (cable_mode == 2'b10 && v != 0) note(F_ACTIVE_BYTE61, a, 1'b0);
            end
            62: if (v & 8'hFE) note(F_BYTE62_RESERVED, a, 1'b0);
            63: if (v != base_sum) note(F_CC_BASE, a, 1'b0);
            64: if (v[7]) note(F_BYTE64_RESERVED, a, 1'b0);
            65: begin
               if ((v & 8'h06) == 8'h06) note(F_BYTE65_CLASH, a, 1'b0);
               if (v[0]) note(F_BYTE65_RESERVED, a, 1'b0);
            end
            66: begin
               if (rate_saturated) begin
                  if (v == 0) note(F_MAX_RATE_ZERO, a, 1'b1);
                  else if (int'(v) * 250 < 25400) note(F_MAX_RATE_LOW, a, 1'b1);
               end
            end
            67: if (v > 8'd100) note(F_MIN_RATE_HIGH, a, 1'b1);
            84, 86, 88: begin
               date_first_ok = is_digit(v);
               date_tens = date_first_ok ? 4'(v - 8'h30) : 4'd0;
            end
            85: if (!date_first_ok || !is_digit(v)) note(F_YEAR, a, 1'b0);
            87: date_pair(a, v, 12, F_MONTH);
            89: date_pair(a, v, 31, F_DAY);
            95: if (v != ext_sum) note(F_CC_EXT, a, 1'b0);
            default: ;
         endcase

         if ((a >= 20 && a <= 35) || a == 90 || a == 91)
            if (!is_printable(v)) note(F_UNPRINTABLE, a, 1'b0);
         held_text(a, v, PART_START, PART_LEN);
         held_text(a, v, REV_START, REV_LEN);
         held_text(a, v, SERIAL_START, SERIAL_LEN);
      end

      if (step_findings.size() == 0) note(F_NONE, a, 1'b0);
      foreach (step_findings[i]) begin
         f = step_findings[i];
         f.last = (i == step_findings.size() - 1);
         findings_due.insert(findings_due.size(), f);
      end
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // Queue one page byte; the idling phase follows its place in the plan
   task automatic plan_byte(input int addr, input int value);
      page_byte_type  b;
      idle_phase_type p;
      int             q;
      q = planned_n * 4 / PLAN_TOTAL;
      if (q > 3) q = 3;
      p = idle_phase_type'(q);
      b.addr  = ADDR_W'(addr);
      b.value = BYTE_W'(value);
      b.phase = p;
      b.drain = drain_next || (p != plan_phase);
      drain_next = 1'b0;
      plan_phase = p;
      byte_plan.insert(byte_plan.size(), b);
      planned_n++;
   endtask

   // Mostly well-formed page with random content, a few corrupted bytes
   task automatic build_page();
      int         cable;
      bit         blank_part;
      bit         blank_rev;
      bit         blank_serial;
      int         year;
      int         month;
      int         day;
      logic [7:0] sum;
      cable = $urandom_range(0, 2);
      blank_part = ($urandom_range(4) == 0);
      blank_rev = ($urandom_range(4) == 0);
      blank_serial = ($urandom_range(4) == 0);
      for (int a = 0; a < 128; a++) page_img[a] = 8'($urandom);

      page_img[0] = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 2)) : 8'h03;
      page_img[1] = 8'($urandom_range(0, 7));
      page_img[2] = $urandom_range(1) ? 8'($urandom_range(0, 8'h0D))
                                      : 8'($urandom_range(8'h20, 8'h28));
      page_img[5] &= 8'h77;
      page_img[8] = (page_img[8] & 8'hF0) | 8'(cable << 2);
      page_img[9] &= 8'hFD;
      page_img[11] = 8'($urandom_range(0, 8));
      page_img[12] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(1, 254));
      case ($urandom_range(5))
         0: page_img[13] = 8'h00;
         1: page_img[13] = 8'h01;
         2: page_img[13] = 8'h02;
         3: page_img[13] = 8'h04;
         4: page_img[13] = 8'h10;
         default: page_img[13] = 8'h20;
      endcase
      for (int a = 20; a <= 35; a++) page_img[a] = printable_char();
      page_img[36] = 8'($urandom_range(0, 9));
      for (int a = 0; a < PART_LEN; a++)
         page_img[PART_START + a] = blank_part ? 8'h00 : printable_char();
      for (int a = 0; a < REV_LEN; a++)
         page_img[REV_START + a] = blank_rev ? 8'h00 : printable_char();
      for (int a = 0; a < SERIAL_LEN; a++)
         page_img[SERIAL_START + a] = blank_serial ? 8'h00 : printable_char();
      if (cable == 1) page_img[60] &= 8'h03;
      if (cable == 2) page_img[60] &= 8'h0F;
      if (cable != 0) page_img[61] = 8'h00;
      page_img[62] &= 8'h01;
      page_img[64] &= 8'h7F;
      page_img[65] = (page_img[65] & 8'hF8) | 8'(2 * $urandom_range(0, 2));
      if (page_img[12] == 8'hFF) page_img[66] = 8'($urandom_range(102, 255));
      page_img[67] = 8'($urandom_range(0, 100));
      year = $urandom_range(0, 99);
      month = $urandom_range(1, 12);
      day = $urandom_range(1, 31);
      page_img[84] = 8'(8'h30 + year / 10);
      page_img[85] = 8'(8'h30 + year % 10);
      page_img[86] = 8'(8'h30 + month / 10);
      page_img[87] = 8'(8'h30 + month % 10);
      page_img[88] = 8'(8'h30 + day / 10);
      page_img[89] = 8'(8'h30 + day % 10);
      page_img[90] = printable_char();
      page_img[91] = printable_char();

      // corrupt a few bytes: a fresh value or one flipped bit
      for (int a = 0; a < 128; a++) begin
         if ($urandom_range(99) < 7) begin
            if ($urandom_range(1)) page_img[a] = 8'($urandom);
            else page_img[a] ^= 8'(1 << $urandom_range(7));
         end
      end

      // checksums, wrong now and then
      sum = '0;
      for (int a = 0; a <= 62; a++) sum += page_img[a];
      page_img[63] = ($urandom_range(7) == 0) ? 8'($urandom) : sum;
      sum = '0;
      for (int a = 64; a <= 94; a++) sum += page_img[a];
      page_img[95] = ($urandom_range(7) == 0) ? 8'($urandom) : sum;
   endtask

   // Driver: presents page bytes from the plan, keeps tvalid up until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) void'(byte_plan.pop_front());
         if (!req_tvalid || req_tready) begin
            if (byte_plan.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               next_byte = byte_plan[0];
               if (next_byte.drain && (req_tvalid || findings_outstanding != 0)) begin
                  req_tvalid <= 1'b0;
               end else if ($urandom_range(99) < send_idle_pct(next_byte.phase)) begin
                  req_tvalid <= 1'b0;
               end else begin
                  req_tvalid <= 1'b1;
                  req_tdata <= {1'b0, next_byte.value, next_byte.addr};
                  idle_phase <= next_byte.phase;
               end
            end
         end
      end
   end

   // Monitor: checks each result transaction, predicts each accepted byte
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            codes_seen[rsp_tdata[CODE_W-1:0]] = 1'b1;
            if (findings_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d at byte %0d",
                        $time, rsp_tdata[4:0], rsp_tdata[11:5]);
               mismatch_count++;
            end else begin
               due = findings_due.pop_front();
               check_field("finding", due.code, rsp_tdata[4:0]);
               check_field("finding_address", due.addr, rsp_tdata[11:5]);
               check_field("is_warning", due.warn, rsp_tuser);
               check_field("last_of_run", due.last, rsp_tlast);
               check_field("tdata padding", 0, rsp_tdata[15:12]);
            end
         end
         if (req_tvalid && req_tready) begin
            byte_count++;
            predict_page_byte(req_tdata[6:0], req_tdata[14:7]);
         end
         findings_outstanding <= findings_due.size();
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct(idle_phase));
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d findings outstanding",
                  $time, findings_due.size());
         $display("[transceiver_id_page_checker] ERROR");
         $finish;
      end
   end

   initial begin
      int pick;
      int first;
      int count;

      // directed: extremes and many of the rules that a single byte can raise
      plan_byte(0, 8'hFF);
      plan_byte(1, 8'h08);
      plan_byte(2, 8'h80);
      plan_byte(8, 8'h0F);     // reserved bits and both cable kinds
      plan_byte(60, 8'hFF);    // clashing cable kinds: no cable checks
      plan_byte(8, 8'h04);     // passive cable
      plan_byte(60, 8'h04);
      plan_byte(61, 8'h01);
      plan_byte(9, 8'h02);
      plan_byte(11, 8'h09);
      plan_byte(12, 8'h00);
      plan_byte(12, 8'hFF);    // saturated nominal rate
      plan_byte(66, 8'h00);
      plan_byte(66, 8'h65);
      plan_byte(13, 8'h03);
      plan_byte(13, 8'hFF);
      plan_byte(36, 8'h82);
      plan_byte(20, 8'h7F);
      plan_byte(62, 8'hFE);
      plan_byte(64, 8'h80);
      plan_byte(65, 8'h07);
      plan_byte(67, 8'hFF);
      plan_byte(85, 8'h30);    // year without a valid first digit
      plan_byte(56, 8'h00);    // revision field with deferred reports
      plan_byte(57, 8'h01);
      plan_byte(58, 8'h7F);
      plan_byte(59, 8'hFF);

      // random: whole pages, in-order slices of pages, and scattered noise
      drain_next = 1'b1;
      while (planned_n < PLAN_TOTAL) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            build_page();
            for (int a = 0; a < 128 && planned_n < PLAN_TOTAL; a++) plan_byte(a, page_img[a]);
         end else if (pick < 85) begin
            build_page();
            first = $urandom_range(0, 127);
            count = $urandom_range(2, 40);
            for (int a = first; a < first + count && a < 128 && planned_n < PLAN_TOTAL; a++)
               plan_byte(a, page_img[a]);
         end else begin
            for (int i = 0; i < 8 && planned_n < PLAN_TOTAL; i++)
               plan_byte($urandom_range(0, 127), $urandom_range(0, 255));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for the plan to drain and every finding to arrive
      @(negedge clock);
      while (byte_plan.size() != 0 || req_tvalid || findings_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (findings_due.size() != 0) begin
         $display("%0t: %0d predicted findings never arrived", $time, findings_due.size());
         mismatch_count++;
      end

      $display("Sent %0d page bytes over four idling phases, checked %0d findings.",
               byte_count, result_count);
      $display("Distinct finding codes observed: %0d of 32, mismatches: %0d.",
               $countones(codes_seen), mismatch_count);
      if (mismatch_count == 0) begin
         $display("[transceiver_id_page_checker] OK");
      end else begin
         $display("[transceiver_id_page_checker] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/tidpc_pkg.sv
rtl/tidpc_front.sv
rtl/tidpc_queue.sv
rtl/tidpc_back.sv
rtl/transceiver_id_page_checker.sv
bench/testbench.sv
